>>> design/lrts_pkg.sv
// Shared types, character codes and limits of the Lisp reader token scanner.
package lrts_pkg;

  // Longest token kept; the next character raises a too-long error.
  localparam logic [7:0] TokenMax = 8'd127;
  // Entries of the queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChFf         = 8'h0C;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChDquote     = 8'h22;
  localparam logic [7:0] ChHash       = 8'h23;
  localparam logic [7:0] ChQuote      = 8'h27;
  localparam logic [7:0] ChLparen     = 8'h28;
  localparam logic [7:0] ChRparen     = 8'h29;
  localparam logic [7:0] ChPlus       = 8'h2B;
  localparam logic [7:0] ChComma      = 8'h2C;
  localparam logic [7:0] ChMinus      = 8'h2D;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChUpperE     = 8'h45;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChBackquote  = 8'h60;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerZ     = 8'h7A;
  localparam logic [7:0] ChBar        = 8'h7C;
  localparam logic [7:0] CaseOffset   = 8'h20;

  typedef enum logic [2:0] {
    CC_CONST = 3'd0,
    CC_WS    = 3'd1,
    CC_TERM  = 3'd2,
    CC_DISP  = 3'd3,
    CC_SESC  = 3'd4,
    CC_MESC  = 3'd5
  } char_class_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_TOKEN = 3'd1,
    MODE_MULTI = 3'd2,
    MODE_ESC   = 3'd3,
    MODE_MESC  = 3'd4,
    MODE_HASH  = 3'd5,
    MODE_HARG  = 3'd6,
    MODE_SKIP  = 3'd7
  } scan_mode_e;

  typedef enum logic [2:0] {
    IC_START  = 3'd0,
    IC_SIGN   = 3'd1,
    IC_DIGITS = 3'd2,
    IC_DOT    = 3'd3,
    IC_REJECT = 3'd4
  } int_chk_e;

  typedef enum logic [3:0] {
    FC_START   = 4'd0,
    FC_SIGN    = 4'd1,
    FC_MANT    = 4'd2,
    FC_POINT   = 4'd3,
    FC_FRAC    = 4'd4,
    FC_EXPMARK = 4'd5,
    FC_EXPSIGN = 4'd6,
    FC_EXP     = 4'd7,
    FC_REJECT  = 4'd15
  } float_chk_e;

  typedef enum logic [2:0] {
    EV_CHAR      = 3'd0,
    EV_TOKEN_END = 3'd1,
    EV_MACRO     = 3'd2,
    EV_DISPATCH  = 3'd3,
    EV_ERROR     = 3'd4,
    EV_END       = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    TC_SYMBOL  = 2'd0,
    TC_INTEGER = 2'd1,
    TC_FLOAT   = 2'd2
  } token_class_e;

  typedef enum logic [1:0] {
    ERR_EOF      = 2'd0,
    ERR_DISPATCH = 2'd1,
    ERR_LONG     = 2'd2,
    ERR_NONE     = 2'd3
  } error_e;

  // One classified input byte, as queued between front and back.
  typedef struct packed {
    logic        eoi;
    logic [7:0]  ch;
    logic [7:0]  upc;
    char_class_e cls;
    logic        digit;
  } item_t;

  // One result beat.
  typedef struct packed {
    event_e       ev;
    logic [7:0]   ch;
    token_class_e cls;
    logic [31:0]  ival;
    logic         argp;
    logic [31:0]  arg;
    error_e       err;
    logic         last;
  } result_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

>>> design/lrts_front.sv
// Front end: input handshake and readtable classification of each byte.
module lrts_front import lrts_pkg::*; (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_code_i,
  input  logic          end_of_input_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output item_t         item_o
);

  char_class_e cls;

  always_comb begin
    case (char_code_i)
      ChNul, ChTab, ChLf, ChFf, ChCr, ChSpace:                       cls = CC_WS;
      ChDquote, ChQuote, ChLparen, ChRparen, ChComma, ChSemi,
      ChBackquote:                                                   cls = CC_TERM;
      ChHash:                                                        cls = CC_DISP;
      ChBackslash:                                                   cls = CC_SESC;
      ChBar:                                                         cls = CC_MESC;
      default:                                                       cls = CC_CONST;
    endcase
  end

  // Stall only on a full queue.
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  assign item_o.eoi   = end_of_input_i;
  assign item_o.ch    = char_code_i;
  assign item_o.upc   = (char_code_i >= ChLowerA && char_code_i <= ChLowerZ) ?
                        (char_code_i - CaseOffset) : char_code_i;
  assign item_o.cls   = cls;
  assign item_o.digit = (char_code_i >= ChZero) && (char_code_i <= ChNine);

endmodule

>>> design/lrts_queue.sv
// Short queue of classified bytes between front and back.
module lrts_queue import lrts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  item_t         item_i,
  input  logic          pop_i,
  output queue_status_t status_o,
  output item_t         item_o
);

  item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));

endmodule

>>> design/lrts_back.sv
// Back end: scanner state machine, token checks and result beat output.
module lrts_back import lrts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_o
);

  function automatic result_t mk_res(event_e ev, logic [7:0] ch, token_class_e cls,
                                     logic [31:0] iv, logic ap, logic [31:0] arg,
                                     error_e err);
    result_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.cls  = cls;
    r.ival = iv;
    r.argp = ap;
    r.arg  = arg;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  scan_mode_e   mode_q, mode_d;
  logic [7:0]   len_q, len_d;
  int_chk_e     ichk_q, ichk_d;
  logic [31:0]  mag_q, mag_d;
  logic         neg_q, neg_d;
  float_chk_e   fchk_q, fchk_d;
  logic [31:0]  arg_q, arg_d;
  logic         seen_q, seen_d;

  result_t      out_q, out_d;
  logic         out_valid_q, out_valid_d;
  result_t      pend_q, pend_d;
  logic         pend_valid_q, pend_valid_d;

  logic         eoi;
  char_class_e  k;

  // Character append decode
  logic         add_w, add_esc_w, add_fresh_w;
  logic [7:0]   add_ch_w;
  logic [7:0]   base_len;
  int_chk_e     base_ichk;
  logic [31:0]  base_mag;
  logic         base_neg;
  float_chk_e   base_fchk;
  logic         add_long_w;
  logic [7:0]   add_len_w;
  int_chk_e     add_ichk_w;
  logic [31:0]  add_mag_w;
  logic         add_neg_w;
  float_chk_e   add_fchk_w;
  logic [31:0]  digit_val;
  logic [31:0]  mag10;
  logic [31:0]  arg10;
  logic         sign_ch, is_plus, is_minus, is_dot, is_e;

  // Results of the head item
  result_t      r0, r1;
  logic [1:0]   n_res;
  result_t      tok_end, add_res;
  logic         valid_sub;

  // Handshake
  logic         out_ready;
  logic         take;

  assign eoi = q_item_i.eoi;
  assign k   = q_item_i.cls;

  // Decide whether this byte appends a token character, and how.
  always_comb begin
    add_w       = 1'b0;
    add_esc_w   = 1'b0;
    add_fresh_w = 1'b0;
    add_ch_w    = q_item_i.ch;
    if (!eoi) begin
      case (mode_q)
        MODE_IDLE: begin
          if (k == CC_CONST) begin
            add_w       = 1'b1;
            add_fresh_w = 1'b1;
            add_ch_w    = q_item_i.upc;
          end
        end
        MODE_TOKEN: begin
          if (k == CC_CONST || k == CC_DISP) begin
            add_w    = 1'b1;
            add_ch_w = q_item_i.upc;
          end
        end
        MODE_ESC, MODE_MESC: begin
          add_w     = 1'b1;
          add_esc_w = 1'b1;
        end
        MODE_MULTI: begin
          if (k != CC_SESC && k != CC_MESC) begin
            add_w     = 1'b1;
            add_esc_w = 1'b1;
          end
        end
        default: begin
          add_w = 1'b0;
        end
      endcase
    end
  end

  // Step the integer and float recognisers over the appended character.
  always_comb begin
    base_len  = add_fresh_w ? '0 : len_q;
    base_ichk = add_fresh_w ? IC_START : ichk_q;
    base_mag  = add_fresh_w ? '0 : mag_q;
    base_neg  = add_fresh_w ? 1'b0 : neg_q;
    base_fchk = add_fresh_w ? FC_START : fchk_q;

    add_long_w = (base_len >= TokenMax);
    add_len_w  = base_len + 8'd1;
    digit_val  = {28'd0, add_ch_w[3:0]};
    mag10      = (base_mag << 3) + (base_mag << 1) + digit_val;
    is_plus    = (add_ch_w == ChPlus);
    is_minus   = (add_ch_w == ChMinus);
    is_dot     = (add_ch_w == ChDot);
    is_e       = (add_ch_w == ChUpperE);
    sign_ch    = is_plus | is_minus;

    add_mag_w = base_mag;
    add_neg_w = base_neg;
    case (base_ichk)
      IC_START: begin
        if (is_plus) begin
          add_ichk_w = IC_SIGN;
        end else if (is_minus) begin
          add_ichk_w = IC_SIGN;
          add_neg_w  = 1'b1;
        end else if (q_item_i.digit) begin
          add_ichk_w = IC_DIGITS;
          add_mag_w  = digit_val;
        end else begin
          add_ichk_w = IC_REJECT;
        end
      end
      IC_SIGN, IC_DIGITS: begin
        if (q_item_i.digit) begin
          add_ichk_w = IC_DIGITS;
          add_mag_w  = mag10;
        end else if (is_dot && base_ichk == IC_DIGITS) begin
          add_ichk_w = IC_DOT;
        end else begin
          add_ichk_w = IC_REJECT;
        end
      end
      default: add_ichk_w = IC_REJECT;
    endcase

    add_fchk_w = FC_REJECT;
    case (base_fchk)
      FC_START: begin
        if (sign_ch)               add_fchk_w = FC_SIGN;
        else if (q_item_i.digit)   add_fchk_w = FC_MANT;
        else if (is_dot)           add_fchk_w = FC_POINT;
      end
      FC_SIGN: begin
        if (q_item_i.digit)        add_fchk_w = FC_MANT;
        else if (is_dot)           add_fchk_w = FC_POINT;
      end
      FC_MANT: begin
        if (q_item_i.digit)        add_fchk_w = FC_MANT;
        else if (is_dot)           add_fchk_w = FC_FRAC;
        else if (is_e)             add_fchk_w = FC_EXPMARK;
      end
      FC_POINT: begin
        if (q_item_i.digit)        add_fchk_w = FC_FRAC;
      end
      FC_FRAC: begin
        if (q_item_i.digit)        add_fchk_w = FC_FRAC;
        else if (is_e)             add_fchk_w = FC_EXPMARK;
      end
      FC_EXPMARK: begin
        if (sign_ch)               add_fchk_w = FC_EXPSIGN;
        else if (q_item_i.digit)   add_fchk_w = FC_EXP;
      end
      FC_EXPSIGN, FC_EXP: begin
        if (q_item_i.digit)        add_fchk_w = FC_EXP;
      end
      default: add_fchk_w = FC_REJECT;
    endcase

    // Any escape makes the token a symbol.
    if (add_esc_w) begin
      add_ichk_w = IC_REJECT;
      add_fchk_w = FC_REJECT;
      add_mag_w  = base_mag;
      add_neg_w  = base_neg;
    end
  end

  assign arg10 = (arg_q << 3) + (arg_q << 1) + {28'd0, q_item_i.upc[3:0]};

  // Next state of the scanner.
  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    ichk_d = ichk_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    fchk_d = fchk_q;
    arg_d  = arg_q;
    seen_d = seen_q;
    if (eoi) begin
      mode_d = MODE_IDLE;
      len_d  = '0;
      ichk_d = IC_START;
      mag_d  = '0;
      neg_d  = 1'b0;
      fchk_d = FC_START;
      arg_d  = '0;
      seen_d = 1'b0;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (k == CC_DISP) begin
            mode_d = MODE_HASH;
            arg_d  = '0;
            seen_d = 1'b0;
          end else if (k == CC_SESC || k == CC_MESC) begin
            mode_d = (k == CC_SESC) ? MODE_ESC : MODE_MULTI;
            len_d  = '0;
            ichk_d = IC_REJECT;
            mag_d  = '0;
            neg_d  = 1'b0;
            fchk_d = FC_REJECT;
          end else if (k == CC_CONST) begin
            mode_d = MODE_TOKEN;
          end
        end
        MODE_TOKEN: begin
          if (k == CC_SESC || k == CC_MESC) begin
            mode_d = (k == CC_SESC) ? MODE_ESC : MODE_MULTI;
            ichk_d = IC_REJECT;
            fchk_d = FC_REJECT;
          end else if (k == CC_TERM || k == CC_WS) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_ESC:  mode_d = MODE_TOKEN;
        MODE_MESC: mode_d = MODE_MULTI;
        MODE_MULTI: begin
          if (k == CC_SESC)      mode_d = MODE_MESC;
          else if (k == CC_MESC) mode_d = MODE_TOKEN;
        end
        MODE_HASH, MODE_HARG: begin
          if (q_item_i.digit) begin
            arg_d  = arg10;
            seen_d = 1'b1;
            mode_d = MODE_HARG;
          end else begin
            mode_d = MODE_IDLE;
            arg_d  = '0;
            seen_d = 1'b0;
          end
        end
        default: begin
          if (k == CC_WS || k == CC_TERM) mode_d = MODE_IDLE;
        end
      endcase
      if (add_w) begin
        if (add_long_w) begin
          mode_d = MODE_SKIP;
        end else begin
          len_d  = add_len_w;
          ichk_d = add_ichk_w;
          mag_d  = add_mag_w;
          neg_d  = add_neg_w;
          fchk_d = add_fchk_w;
        end
      end
    end
  end

  // Result beats caused by the head item.
  always_comb begin
    if (ichk_q == IC_DIGITS || ichk_q == IC_DOT) begin
      tok_end = mk_res(EV_TOKEN_END, '0, TC_INTEGER, neg_q ? (32'd0 - mag_q) : mag_q,
                       1'b0, '0, ERR_NONE);
    end else if (fchk_q == FC_MANT || fchk_q == FC_FRAC || fchk_q == FC_EXP) begin
      tok_end = mk_res(EV_TOKEN_END, '0, TC_FLOAT, '0, 1'b0, '0, ERR_NONE);
    end else begin
      tok_end = mk_res(EV_TOKEN_END, '0, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
    end
    add_res = add_long_w ? mk_res(EV_ERROR, '0, TC_SYMBOL, '0, 1'b0, '0, ERR_LONG)
                         : mk_res(EV_CHAR, add_ch_w, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
    valid_sub = (q_item_i.upc == ChQuote) || (q_item_i.upc == ChLparen) ||
                (q_item_i.upc == ChBackslash) || (q_item_i.upc == ChBar);

    r0    = mk_res(EV_END, '0, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
    r1    = mk_res(EV_END, '0, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
    n_res = 2'd0;
    if (eoi) begin
      if (mode_q == MODE_TOKEN) begin
        r0    = tok_end;
        n_res = 2'd2;
      end else if (mode_q != MODE_IDLE && mode_q != MODE_SKIP) begin
        r0    = mk_res(EV_ERROR, '0, TC_SYMBOL, '0, 1'b0, '0, ERR_EOF);
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (add_w) begin
      r0    = add_res;
      n_res = 2'd1;
    end else begin
      case (mode_q)
        MODE_IDLE, MODE_SKIP: begin
          if (k == CC_TERM) begin
            r0    = mk_res(EV_MACRO, q_item_i.ch, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
            n_res = 2'd1;
          end
        end
        MODE_TOKEN: begin
          if (k == CC_TERM) begin
            r0    = tok_end;
            r1    = mk_res(EV_MACRO, q_item_i.ch, TC_SYMBOL, '0, 1'b0, '0, ERR_NONE);
            n_res = 2'd2;
          end else if (k == CC_WS) begin
            r0    = tok_end;
            n_res = 2'd1;
          end
        end
        MODE_HASH, MODE_HARG: begin
          if (!q_item_i.digit) begin
            r0 = valid_sub ?
                 mk_res(EV_DISPATCH, q_item_i.upc, TC_SYMBOL, '0, seen_q, arg_q, ERR_NONE) :
                 mk_res(EV_ERROR, q_item_i.upc, TC_SYMBOL, '0, 1'b0, '0, ERR_DISPATCH);
            n_res = 2'd1;
          end
        end
        default: n_res = 2'd0;
      endcase
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // Output register plus a pending slot for an item's second beat.
  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign take      = ~pend_valid_q & q_valid_i & (out_ready | (n_res == 2'd0));
  assign q_pop_o   = take;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (pend_valid_q) begin
      if (out_ready) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end
    end else if (take) begin
      if (n_res != 2'd0) begin
        out_d       = r0;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = out_valid_q & ~out_ready;
      end
      if (n_res == 2'd2) begin
        pend_d       = r1;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      len_q        <= '0;
      ichk_q       <= IC_START;
      mag_q        <= '0;
      neg_q        <= 1'b0;
      fchk_q       <= FC_START;
      arg_q        <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        ichk_q <= ichk_d;
        mag_q  <= mag_d;
        neg_q  <= neg_d;
        fchk_q <= fchk_d;
        arg_q  <= arg_d;
        seen_q <= seen_d;
      end
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/lisp_reader_token_scanner.sv
// Top level of the Lisp reader token scanner: front, queue and back end.
//
// Feed one source byte, or an end-of-input mark, per beat; the scanner classifies it with
// the default readtable and returns token characters (upper-cased unless escaped), token
// ends classed as symbol, integer (with its 32-bit wrapped value) or float, macro
// characters, '#' dispatches with their optional decimal argument, coded errors and an
// end event. The last beat caused by an input byte carries last_o. Rate: one input byte
// per clock cycle while the queue has room; a byte that yields no or one result beat frees
// the back end for the next byte, while a byte that yields two (a token end followed by a
// macro character, or a token end or error followed by the end event) holds the back end
// until its second beat reaches the output register. A four-entry queue between the
// classifying front and the scanning back end absorbs these bursts and output stalls, and
// the back end's state update (a times-ten accumulate on the integer or argument value)
// sets the clock limit. No clearing pass follows reset: input is taken once reset ends.
module lisp_reader_token_scanner import lrts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_input_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         event_res_o,
  output logic [7:0]         out_char_o,
  output logic [1:0]         token_class_o,
  output logic signed [31:0] int_value_o,
  output logic               arg_present_o,
  output logic [31:0]        dispatch_arg_o,
  output logic [1:0]         error_code_o,
  output logic               last_o
);

  queue_status_t q_status;
  item_t         push_item;
  item_t         head_item;
  logic          push;
  logic          pop;
  result_t       res;

  // Classify each beat and push it while the queue has room.
  lrts_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .item_o         (push_item)
  );

  // Decouple the input handshake from back-end stalls.
  lrts_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .status_o (q_status),
    .item_o   (head_item)
  );

  // Run the scanner and drive the registered output beat.
  lrts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_status.valid),
    .q_item_i    (head_item),
    .q_pop_o     (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  // Unpack the result beat onto the output fields.
  assign event_res_o    = res.ev;
  assign out_char_o     = res.ch;
  assign token_class_o  = res.cls;
  assign int_value_o    = signed'(res.ival);
  assign arg_present_o  = res.argp;
  assign dispatch_arg_o = res.arg;
  assign error_code_o   = res.err;
  assign last_o         = res.last;

  // The second beat of an item follows its first without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("second result beat did not follow");

  // The end event is always the final beat of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_END) |-> last_o)
    else $error("end event without last");

  // Error beats carry a real error code, all others carry none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_res_o == EV_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match event");

  // A token class other than symbol appears only on a token end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_class_o != TC_SYMBOL) |-> (event_res_o == EV_TOKEN_END))
    else $error("token class outside token end");

endmodule

>>> verif/lrts_tb_pkg.sv
// Character helpers and the scoreboard class for the token scanner testbench.
`timescale 1ns / 1ps
package lrts_tb_pkg;
  import lrts_pkg::*;

  function automatic char_class_e class_of(logic [7:0] c);
    case (c)
      ChNul, ChTab, ChLf, ChFf, ChCr, ChSpace: return CC_WS;
      ChDquote, ChQuote, ChLparen, ChRparen, ChComma, ChSemi, ChBackquote: return CC_TERM;
      ChHash: return CC_DISP;
      ChBackslash: return CC_SESC;
      ChBar: return CC_MESC;
      default: return CC_CONST;
    endcase
  endfunction

  function automatic logic [7:0] upper(logic [7:0] c);
    return (c >= ChLowerA && c <= ChLowerZ) ? c - CaseOffset : c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  class scan_scoreboard;
    scan_mode_e  mode;
    logic [7:0]  tok_len;
    int_chk_e    int_chk;
    logic [31:0] magnitude;
    logic        negative;
    float_chk_e  float_chk;
    logic [31:0] arg_acc;
    logic        arg_seen;
    result_t     due_beats[$];
    result_t     fresh[$];
    int unsigned fault_count;
    int unsigned beat_count;

    function new();
      restart();
      fault_count = 0;
      beat_count = 0;
    endfunction

    function void clear_token();
      tok_len = '0;
      int_chk = IC_START;
      magnitude = '0;
      negative = 1'b0;
      float_chk = FC_START;
    endfunction

    function void restart();
      mode = MODE_IDLE;
      clear_token();
      arg_acc = '0;
      arg_seen = 1'b0;
    endfunction

    function void reject_numeric();
      int_chk = IC_REJECT;
      float_chk = FC_REJECT;
    endfunction

    function result_t beat(event_e ev, logic [7:0] ch, error_e err);
      result_t r;
      r = '0;
      r.ev = ev;
      r.ch = ch;
      r.err = err;
      return r;
    endfunction

    function void step_int(logic [7:0] c);
      case (int_chk)
        IC_START:
          if (c == ChPlus) int_chk = IC_SIGN;
          else if (c == ChMinus) begin
            int_chk = IC_SIGN;
            negative = 1'b1;
          end else if (is_digit(c)) begin
            int_chk = IC_DIGITS;
            magnitude = {24'd0, c - ChZero};
          end else int_chk = IC_REJECT;
        IC_SIGN, IC_DIGITS:
          if (is_digit(c)) begin
            int_chk = IC_DIGITS;
            magnitude = magnitude * 32'd10 + {24'd0, c - ChZero};
          end else if (c == ChDot && int_chk == IC_DIGITS) int_chk = IC_DOT;
          else int_chk = IC_REJECT;
        default: int_chk = IC_REJECT;
      endcase
    endfunction

    function void step_float(logic [7:0] c);
      logic       d;
      float_chk_e t;
      d = is_digit(c);
      t = FC_REJECT;
      case (float_chk)
        FC_START:
          if (c == ChPlus || c == ChMinus) t = FC_SIGN;
          else if (d) t = FC_MANT;
          else if (c == ChDot) t = FC_POINT;
        FC_SIGN:
          if (d) t = FC_MANT;
          else if (c == ChDot) t = FC_POINT;
        FC_MANT:
          if (d) t = FC_MANT;
          else if (c == ChDot) t = FC_FRAC;
          else if (c == ChUpperE) t = FC_EXPMARK;
        FC_POINT: if (d) t = FC_FRAC;
        FC_FRAC:
          if (d) t = FC_FRAC;
          else if (c == ChUpperE) t = FC_EXPMARK;
        FC_EXPMARK:
          if (c == ChPlus || c == ChMinus) t = FC_EXPSIGN;
          else if (d) t = FC_EXP;
        FC_EXPSIGN: if (d) t = FC_EXP;
        FC_EXP: if (d) t = FC_EXP;
        default: ;
      endcase
      float_chk = t;
    endfunction

    function void add_char(logic [7:0] c, logic escaped);
      if (tok_len >= TokenMax) begin
        fresh.push_back(beat(EV_ERROR, 8'h00, ERR_LONG));
        mode = MODE_SKIP;
        return;
      end
      tok_len++;
      if (escaped) reject_numeric();
      else begin
        step_int(c);
        step_float(c);
      end
      fresh.push_back(beat(EV_CHAR, c, ERR_NONE));
    endfunction

    function void close_token();
      result_t r;
      r = beat(EV_TOKEN_END, 8'h00, ERR_NONE);
      if (int_chk == IC_DIGITS || int_chk == IC_DOT) begin
        r.cls = TC_INTEGER;
        r.ival = negative ? 32'd0 - magnitude : magnitude;
      end else if (float_chk inside {FC_MANT, FC_FRAC, FC_EXP}) begin
        r.cls = TC_FLOAT;
      end
      fresh.push_back(r);
      mode = MODE_IDLE;
    endfunction

    // Advance the predicted scanner by one accepted byte and queue its beats.
    function void take_byte(logic [7:0] c, logic eoi);
      char_class_e k;
      logic [7:0]  u;
      result_t     r;
      fresh.delete();
      k = class_of(c);
      u = upper(c);
      if (eoi) begin
        if (mode == MODE_TOKEN) close_token();
        else if (mode != MODE_IDLE && mode != MODE_SKIP)
          fresh.push_back(beat(EV_ERROR, 8'h00, ERR_EOF));
        fresh.push_back(beat(EV_END, 8'h00, ERR_NONE));
        restart();
      end else begin
        case (mode)
          MODE_IDLE:
            case (k)
              CC_TERM: fresh.push_back(beat(EV_MACRO, c, ERR_NONE));
              CC_DISP: begin
                mode = MODE_HASH;
                arg_acc = '0;
                arg_seen = 1'b0;
              end
              CC_SESC: begin
                clear_token();
                reject_numeric();
                mode = MODE_ESC;
              end
              CC_MESC: begin
                clear_token();
                reject_numeric();
                mode = MODE_MULTI;
              end
              CC_CONST: begin
                clear_token();
                mode = MODE_TOKEN;
                add_char(u, 1'b0);
              end
              default: ;
            endcase
          MODE_TOKEN:
            case (k)
              CC_CONST, CC_DISP: add_char(u, 1'b0);
              CC_SESC: begin
                reject_numeric();
                mode = MODE_ESC;
              end
              CC_MESC: begin
                reject_numeric();
                mode = MODE_MULTI;
              end
              CC_TERM: begin
                close_token();
                fresh.push_back(beat(EV_MACRO, c, ERR_NONE));
              end
              default: close_token();
            endcase
          MODE_ESC: begin
            mode = MODE_TOKEN;
            add_char(c, 1'b1);
          end
          MODE_MESC: begin
            mode = MODE_MULTI;
            add_char(c, 1'b1);
          end
          MODE_MULTI:
            if (k == CC_SESC) mode = MODE_MESC;
            else if (k == CC_MESC) mode = MODE_TOKEN;
            else add_char(c, 1'b1);
          MODE_HASH, MODE_HARG:
            if (is_digit(u)) begin
              arg_acc = arg_acc * 32'd10 + {24'd0, u - ChZero};
              arg_seen = 1'b1;
              mode = MODE_HARG;
            end else begin
              if (u == ChQuote || u == ChLparen || u == ChBackslash || u == ChBar) begin
                r = beat(EV_DISPATCH, u, ERR_NONE);
                r.argp = arg_seen;
                r.arg = arg_acc;
                fresh.push_back(r);
              end else begin
                fresh.push_back(beat(EV_ERROR, u, ERR_DISPATCH));
              end
              mode = MODE_IDLE;
              arg_acc = '0;
              arg_seen = 1'b0;
            end
          default:
            if (k == CC_WS) mode = MODE_IDLE;
            else if (k == CC_TERM) begin
              mode = MODE_IDLE;
              fresh.push_back(beat(EV_MACRO, c, ERR_NONE));
            end
        endcase
      end
      if (fresh.size() != 0) begin
        r = fresh.pop_back();
        r.last = 1'b1;
        fresh.push_back(r);
      end
      foreach (fresh[i]) due_beats.push_back(fresh[i]);
    endfunction

    function string show(result_t r);
      return $sformatf("ev=%0d ch=%02h cls=%0d ival=%08h argp=%0b arg=%08h err=%0d last=%0b",
                       r.ev, r.ch, r.cls, r.ival, r.argp, r.arg, r.err, r.last);
    endfunction

    // Compare one accepted result beat against the oldest expectation.
    function void check_beat(result_t got);
      result_t want;
      beat_count++;
      if (due_beats.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("beat %0d arrived with nothing expected: %s", beat_count, show(got));
        return;
      end
      want = due_beats.pop_front();
      if (got.ev !== want.ev || got.ch !== want.ch || got.cls !== want.cls ||
          got.ival !== want.ival || got.argp !== want.argp || got.arg !== want.arg ||
          got.err !== want.err || got.last !== want.last) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("beat %0d mismatch", beat_count);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

>>> verif/lisp_reader_token_scanner_tb.sv
// Self-checking testbench top for the Lisp reader token scanner.
`timescale 1ns / 1ps
module lisp_reader_token_scanner_tb;
  import lrts_pkg::*;
  import lrts_tb_pkg::*;

  // Random source bytes after the directed opening.
  localparam int unsigned RandomBytes = 750;
  // Long receiver hold-off, enough to fill the four-entry queue many times over.
  localparam int unsigned HoldCycles = 120;
  // Cycles to let the pipeline settle once nothing is expected.
  localparam int unsigned SettleCycles = 20;
  // Watchdog: far beyond the slowest legal run with heavy stalls and gaps.
  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_pattern_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_code_i;
  logic               end_of_input_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         event_res_o;
  logic [7:0]         out_char_o;
  logic [1:0]         token_class_o;
  logic signed [31:0] int_value_o;
  logic               arg_present_o;
  logic [31:0]        dispatch_arg_o;
  logic [1:0]         error_code_o;
  logic               last_o;

  lisp_reader_token_scanner uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .out_char_o     (out_char_o),
    .token_class_o  (token_class_o),
    .int_value_o    (int_value_o),
    .arg_present_o  (arg_present_o),
    .dispatch_arg_o (dispatch_arg_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o)
  );

  scan_scoreboard board;
  int unsigned    bytes_taken = 0;   // input beats accepted by the block
  int unsigned    bytes_offered = 0; // input beats presented by the sender
  int unsigned    burst_left = 0;
  int unsigned    cycle_count = 0;
  bit             no_gaps = 1'b0;     // sender runs flat out while set
  bit             squeeze_req = 1'b0; // asks the receiver for its long hold-off

  always #1 clk_i = ~clk_i;

  // Sample both channels at the rising edge, before the block updates. Take the
  // input beat first so the prediction is in place before any result is checked.
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.take_byte(char_code_i, end_of_input_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '0;
        got.ev = event_e'(event_res_o);
        got.ch = out_char_o;
        got.cls = token_class_e'(token_class_o);
        got.ival = int_value_o;
        got.argp = arg_present_o;
        got.arg = dispatch_arg_o;
        got.err = error_e'(error_code_o);
        got.last = last_o;
        board.check_beat(got);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall on a pattern of its own, picked anew after each random span, and
  // honour one long hold-off when the stimulus asks for it.
  initial begin : receiver
    stall_pattern_e pattern;
    int unsigned    span;
    int unsigned    k;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (squeeze_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        squeeze_req = 1'b0;
      end
      pattern = stall_pattern_e'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      for (k = 0; k < span && !squeeze_req; k++) begin
        @(negedge clk_i);
        case (pattern)
          STALL_NONE: out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i = ($urandom_range(0, 9) < 7);
          default: out_stall_i = k[0];
        endcase
      end
    end
  end

  // Present one beat at the falling edge and hold it until accepted. Bursts of
  // random length are separated by random gaps unless no_gaps is set.
  task automatic put(input logic [7:0] ch, input logic eoi);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    char_code_i = ch;
    end_of_input_i = eoi;
    in_valid_i = 1'b1;
    seen = bytes_taken;
    bytes_offered++;
    do @(negedge clk_i); while (bytes_taken == seen);
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (board.due_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put(s[i], 1'b0);
  endtask

  function automatic logic [7:0] any_ws();
    case ($urandom_range(0, 5))
      0: return ChNul;
      1: return ChTab;
      2: return ChLf;
      3: return ChFf;
      4: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] any_term();
    case ($urandom_range(0, 6))
      0: return ChDquote;
      1: return ChQuote;
      2: return ChLparen;
      3: return ChRparen;
      4: return ChComma;
      5: return ChSemi;
      default: return ChBackquote;
    endcase
  endfunction

  function automatic logic [7:0] any_digit();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = ChLowerA + 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? c : c - CaseOffset;
  endfunction

  function automatic logic [7:0] any_constituent();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (class_of(c) != CC_CONST);
    return c;
  endfunction

  // Close a token: mostly whitespace or a terminating macro, sometimes end of
  // input, now and then nothing so the next sequence runs on into it.
  task automatic put_delim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) put(any_ws(), 1'b0);
    else if (pick < 17) put(any_term(), 1'b0);
    else if (pick < 19) put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic put_sign();
    case ($urandom_range(0, 3))
      0: put(ChPlus, 1'b0);
      1: put(ChMinus, 1'b0);
      default: ;
    endcase
  endtask

  // Decimal integer; up to twelve digits so the value wraps at 32 bits.
  task automatic put_integer();
    int unsigned n;
    put_sign();
    n = $urandom_range(1, 12);
    repeat (n) put(any_digit(), 1'b0);
    if ($urandom_range(0, 3) == 0) put(ChDot, 1'b0);
    put_delim();
  endtask

  // Float-like text, sometimes broken by a second point or an empty exponent.
  task automatic put_float();
    int unsigned n;
    if ($urandom_range(0, 1)) put_sign();
    n = $urandom_range(0, 4);
    repeat (n) put(any_digit(), 1'b0);
    if ($urandom_range(0, 4) != 0) put(ChDot, 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) put(any_digit(), 1'b0);
    if ($urandom_range(0, 9) == 0) put(ChDot, 1'b0);
    if ($urandom_range(0, 4) < 3) begin
      put($urandom_range(0, 1) ? ChUpperE : ChUpperE + CaseOffset, 1'b0);
      if ($urandom_range(0, 1)) put_sign();
      n = $urandom_range(0, 3);
      repeat (n) put(any_digit(), 1'b0);
    end
    put_delim();
  endtask

  task automatic put_symbol();
    int unsigned n;
    put(any_letter(), 1'b0);
    n = $urandom_range(0, 9);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: put(any_digit(), 1'b0);
        2: put(ChHash, 1'b0);
        3, 4: put(any_constituent(), 1'b0);
        default: put(any_letter(), 1'b0);
      endcase
    end
    put_delim();
  endtask

  // Token with a single escape or a bar-delimited run of arbitrary bytes.
  task automatic put_escaped();
    int unsigned n;
    n = $urandom_range(0, 3);
    repeat (n) put(any_letter(), 1'b0);
    if ($urandom_range(0, 1)) begin
      put(ChBackslash, 1'b0);
      put(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      put(ChBar, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) put(ChBackslash, 1'b0);
        put(8'($urandom_range(0, 255)), 1'b0);
      end
      put(ChBar, 1'b0);
    end
    n = $urandom_range(0, 3);
    repeat (n) put(any_letter(), 1'b0);
    put_delim();
  endtask

  // Hash dispatch with an optional decimal argument that may wrap.
  task automatic put_dispatch();
    int unsigned n;
    put(ChHash, 1'b0);
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 11);
      repeat (n) put(any_digit(), 1'b0);
    end
    case ($urandom_range(0, 9))
      0, 1: put(ChQuote, 1'b0);
      2, 3: put(ChLparen, 1'b0);
      4: put(ChBackslash, 1'b0);
      5: put(ChBar, 1'b0);
      6, 7: put(any_letter(), 1'b0);
      default: put(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // Token of n characters; past the length limit the tail is dropped, escapes
  // included, up to the delimiter.
  task automatic put_long(input int unsigned n);
    put(any_letter(), 1'b0);
    repeat (n - 1) put($urandom_range(0, 3) ? any_letter() : any_digit(), 1'b0);
    if ($urandom_range(0, 1)) begin
      put($urandom_range(0, 1) ? ChBar : ChBackslash, 1'b0);
      put(any_letter(), 1'b0);
    end
    put_delim();
  endtask

  initial begin : stimulus
    int unsigned start;
    bit          paused;
    board = new();
    in_valid_i = 1'b0;
    char_code_i = 8'h00;
    end_of_input_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening:
    // signed integer with trailing dot, ended by a NUL whitespace byte;
    put_text("-12.");
    put(ChNul, 1'b0);
    // empty exponent gives a symbol, closed by a terminating macro (two beats);
    put_text("1.5E(");
    // dispatch with a decimal argument, then an invalid lower-case sub-char;
    put_text("#12(");
    put_text("#z");
    // multiple and single escapes inside one token, a top-bit constituent,
    // then end of input while an escape is pending (error then end).
    put_text("a|b\\c|");
    put(8'hFF, 1'b0);
    put(ChBackslash, 1'b0);
    put(8'h00, 1'b1);
    drain();

    // Random part. Open with a long token while the receiver holds off, so the
    // queue fills and the input channel stalls.
    start = bytes_offered;
    paused = 1'b0;
    squeeze_req = 1'b1;
    no_gaps = 1'b1;
    put_long(TokenMax + 3);
    no_gaps = 1'b0;
    while (bytes_offered - start < RandomBytes) begin
      // Pause once midway until every expected beat is back.
      if (!paused && bytes_offered - start >= RandomBytes / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
      case ($urandom_range(0, 39))
        0, 1, 2, 3, 4, 5, 6, 7: put_integer();
        8, 9, 10, 11, 12, 13: put_float();
        14, 15, 16, 17, 18, 19, 20: put_symbol();
        21, 22, 23, 24, 25: put_escaped();
        26, 27, 28, 29, 30, 31: put_dispatch();
        32, 33: put(any_term(), 1'b0);
        34, 35: put(any_ws(), 1'b0);
        36, 37: repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)), 1'b0);
        38: put(8'($urandom_range(0, 255)), 1'b1);
        default:
          // Rarely a token right at the length limit; short symbols otherwise.
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
              0: put_long(TokenMax - 1);
              1: put_long(TokenMax);
              2: put_long(TokenMax + 1);
              default: put_long(TokenMax + 8);
            endcase
          end else begin
            put_symbol();
          end
      endcase
    end
    drain();

    if (board.fault_count == 0 && board.due_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lrts_pkg.sv
design/lrts_front.sv
design/lrts_queue.sv
design/lrts_back.sv
design/lisp_reader_token_scanner.sv
verif/lrts_tb_pkg.sv
verif/lisp_reader_token_scanner_tb.sv
